// ===== rtl/core/fts_pkg.sv =====
// Shared types and constants of the fair task scheduler.
package fts_pkg;
    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_BLOCKED  = 3'd4;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_YIELD = 3'd1;
    localparam logic [2:0] OP_SLEEP = 3'd2;
    localparam logic [2:0] OP_BLOCK = 3'd3;
    localparam logic [2:0] OP_EXIT  = 3'd4;
    localparam logic [2:0] OP_WAKE  = 3'd5;
    localparam logic [2:0] OP_READY = 3'd6;
    localparam logic [2:0] OP_CREATE = 3'd7;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_IDLE   = 2'd1;
    localparam logic [1:0] STS_FULL   = 2'd2;
    localparam logic [1:0] STS_NOCUR  = 2'd3;

    // Byte addresses of the configuration registers.
    localparam logic [2:0] REG_SLICE  = 3'd0;
    localparam logic [2:0] REG_CHARGE = 3'd4;

    localparam logic [7:0]  SLICE_RESET  = 8'd10;
    localparam logic [31:0] CHARGE_RESET = 32'd1000000;

    // Scan control handed from the sequencer to the scan unit.
    typedef struct packed {
        logic start;
        logic [1:0] mode; // 0 pick, 1 load count, 2 free search
    } scan_ctl_t;

    localparam logic [1:0] SCAN_PICK = 2'd0;
    localparam logic [1:0] SCAN_LOAD = 2'd1;
    localparam logic [1:0] SCAN_FREE = 2'd2;

    // Weight shift from the stored niceness: 10 - nice, at most 30, zero from nice 10 up.
    function automatic logic [4:0] nice_shift(input logic [5:0] nv);
        logic signed [5:0] n;
        n = $signed(nv);
        if (n < -6'sd20) n = -6'sd20;
        if (n >= 6'sd10) return 5'd0;
        return 5'(10 - int'(n));
    endfunction
endpackage

// ===== rtl/core/fair_task_scheduler.sv =====
// Top level of the fair task scheduler: task table, sequencer and a shared scan unit.
//
// Channel   Dir  Fields (tdata low bit up)
// s_axis    in   operation[2:0] cpu[4:3] pid[8:5] sleep_ticks[40:9] nice[46:41]
// m_axis    out  status switched run_valid run_pid fresh_start new_pid load
// apb       cfg  slice_ticks @0, tick_charge @4
//
// Each item walks the task table entry by entry through one comparator. Wake,
// make-ready and an ignored event run only the load count; a tick that keeps its
// task runs the wake sweep before it, create the free search, and yield, sleep,
// block and exit the minimum search; a tick that reschedules runs the wake sweep,
// the minimum search and the load count. Each of these visits every entry once.
// s_tready is high only while the sequencer is idle and the output register is
// empty, so it returns in the cycle after the result is taken.
// Reset is synchronous on aresetn and frees every entry at once through the state flops.
module fair_task_scheduler #(
    parameter int ENTRIES = 16,
    parameter int CPUS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata, // operation, cpu, pid, sleep_ticks, nice
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata, // status, switched, run_valid, run_pid, fresh_start, new_pid, load
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int LW = $clog2(ENTRIES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WAKE  = 4'd1;
    localparam logic [3:0] S_TICK  = 4'd2;
    localparam logic [3:0] S_PICK  = 4'd3;
    localparam logic [3:0] S_PWAIT = 4'd4;
    localparam logic [3:0] S_DISP  = 4'd5;
    localparam logic [3:0] S_FREE  = 4'd6;
    localparam logic [3:0] S_FWAIT = 4'd7;
    localparam logic [3:0] S_LOAD  = 4'd8;
    localparam logic [3:0] S_LWAIT = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [7:0]  slice_ticks_reg;
    logic [31:0] tick_charge_reg;
    logic [2:0]  st_reg [ENTRIES];
    logic        bound_reg [ENTRIES];
    logic [CW-1:0] tcpu_reg [ENTRIES];
    logic [63:0] rt_reg [ENTRIES];
    logic [7:0]  sl_reg [ENTRIES];
    logic [5:0]  nice_reg [ENTRIES];
    logic [31:0] wake_reg [ENTRIES];
    logic        first_reg [ENTRIES];
    logic [31:0] tick_counter_reg;
    logic        cur_v_reg [CPUS];
    logic [IW-1:0] cur_reg [CPUS];

    logic [3:0]  state_reg;
    logic [IW-1:0] widx_reg;
    logic [CW-1:0] cpu_reg;
    logic [5:0]  nin_reg;
    logic        prev_v_reg;
    logic [IW-1:0] prev_reg;
    logic [1:0]  status_reg;
    logic        fresh_reg;
    logic [3:0]  newp_reg;
    logic        tickmode_reg;
    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    // Scan unit hookup.
    fts_pkg::scan_ctl_t ctl;
    logic scan_done;
    logic scan_found;
    logic [IW-1:0] scan_idx;
    logic [LW-1:0] scan_cnt;
    logic [IW-1:0] scan_ptr;
    logic [2:0] e_st;
    logic e_bound;
    logic [CW-1:0] e_cpu;
    logic [63:0] e_rt;
    logic [63:0] best_rt;

    assign e_st = st_reg[scan_ptr];
    assign e_bound = bound_reg[scan_ptr];
    assign e_cpu = tcpu_reg[scan_ptr];
    assign e_rt = rt_reg[scan_ptr];
    assign best_rt = rt_reg[scan_idx];

    fts_scan #(.ENTRIES(ENTRIES), .CPUS(CPUS)) u_scan (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .cpu(cpu_reg),
        .ptr(scan_ptr), .e_st(e_st), .e_bound(e_bound), .e_cpu(e_cpu),
        .e_rt(e_rt), .best_rt(best_rt), .done(scan_done), .found(scan_found),
        .idx(scan_idx), .cnt(scan_cnt)
    );

    logic [CW-1:0] in_cpu;
    always_comb begin
        if (CPUS == 1 || int'(s_tdata[4:3]) >= CPUS) in_cpu = '0;
        else in_cpu = CW'(s_tdata[4:3]);
    end

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2]) prdata = tick_charge_reg;
        else prdata = {24'd0, slice_ticks_reg};
    end

    logic [IW-1:0] cur_idx;
    logic cur_v;
    assign cur_idx = cur_reg[cpu_reg];
    assign cur_v = cur_v_reg[cpu_reg];

    always_comb begin
        ctl.start = 1'b0;
        ctl.mode = fts_pkg::SCAN_PICK;
        unique case (state_reg)
            S_PICK: begin ctl.start = 1'b1; ctl.mode = fts_pkg::SCAN_PICK; end
            S_FREE: begin ctl.start = 1'b1; ctl.mode = fts_pkg::SCAN_FREE; end
            S_LOAD: begin ctl.start = 1'b1; ctl.mode = fts_pkg::SCAN_LOAD; end
            default: ;
        endcase
    end

    logic [4:0] load_sat;
    always_comb begin
        load_sat = (LW > 5 && scan_cnt > LW'(31)) ? 5'd31 : 5'(scan_cnt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            slice_ticks_reg <= fts_pkg::SLICE_RESET;
            tick_charge_reg <= fts_pkg::CHARGE_RESET;
            tick_counter_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                st_reg[i] <= fts_pkg::ST_FREE;
                bound_reg[i] <= 1'b0;
                rt_reg[i] <= '0;
                sl_reg[i] <= fts_pkg::SLICE_RESET;
                nice_reg[i] <= '0;
                wake_reg[i] <= '0;
                first_reg[i] <= 1'b0;
            end
            for (int c = 0; c < CPUS; c++) cur_v_reg[c] <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == fts_pkg::REG_SLICE) slice_ticks_reg <= pwdata[7:0];
                else if (paddr == fts_pkg::REG_CHARGE) tick_charge_reg <= pwdata;
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    cpu_reg <= in_cpu;
                    nin_reg <= s_tdata[46:41];
                    prev_v_reg <= cur_v_reg[in_cpu];
                    prev_reg <= cur_reg[in_cpu];
                    status_reg <= fts_pkg::STS_OK;
                    fresh_reg <= 1'b0;
                    newp_reg <= '0;
                    tickmode_reg <= 1'b0;
                    widx_reg <= '0;
                    unique case (s_tdata[2:0])
                        fts_pkg::OP_TICK: begin
                            tick_counter_reg <= tick_counter_reg + 32'd1;
                            state_reg <= S_WAKE;
                        end
                        fts_pkg::OP_YIELD: begin
                            if (cur_v_reg[in_cpu] &&
                                st_reg[cur_reg[in_cpu]] == fts_pkg::ST_RUNNING)
                                st_reg[cur_reg[in_cpu]] <= fts_pkg::ST_READY;
                            cur_v_reg[in_cpu] <= 1'b0;
                            state_reg <= S_PICK;
                        end
                        fts_pkg::OP_SLEEP, fts_pkg::OP_BLOCK, fts_pkg::OP_EXIT: begin
                            if (!cur_v_reg[in_cpu]) begin
                                status_reg <= fts_pkg::STS_NOCUR;
                                state_reg <= S_LOAD;
                            end else begin
                                if (s_tdata[2:0] == fts_pkg::OP_SLEEP) begin
                                    wake_reg[cur_reg[in_cpu]] <= tick_counter_reg +
                                                                 s_tdata[40:9];
                                    st_reg[cur_reg[in_cpu]] <= fts_pkg::ST_SLEEPING;
                                end else if (s_tdata[2:0] == fts_pkg::OP_BLOCK)
                                    st_reg[cur_reg[in_cpu]] <= fts_pkg::ST_BLOCKED;
                                else st_reg[cur_reg[in_cpu]] <= fts_pkg::ST_FREE;
                                cur_v_reg[in_cpu] <= 1'b0;
                                state_reg <= S_PICK;
                            end
                        end
                        fts_pkg::OP_WAKE: begin
                            if (int'(s_tdata[8:5]) < ENTRIES &&
                                st_reg[IW'(s_tdata[8:5])] == fts_pkg::ST_BLOCKED)
                                st_reg[IW'(s_tdata[8:5])] <= fts_pkg::ST_READY;
                            state_reg <= S_LOAD;
                        end
                        fts_pkg::OP_READY: begin
                            if (int'(s_tdata[8:5]) < ENTRIES &&
                                st_reg[IW'(s_tdata[8:5])] != fts_pkg::ST_FREE)
                                st_reg[IW'(s_tdata[8:5])] <= fts_pkg::ST_READY;
                            state_reg <= S_LOAD;
                        end
                        default: state_reg <= S_FREE;
                    endcase
                end
                S_WAKE: begin
                    // One entry per cycle for the sleeper check.
                    if (st_reg[widx_reg] == fts_pkg::ST_SLEEPING &&
                        tick_counter_reg >= wake_reg[widx_reg])
                        st_reg[widx_reg] <= fts_pkg::ST_READY;
                    widx_reg <= widx_reg + 1'b1;
                    if (int'(widx_reg) == ENTRIES - 1) state_reg <= S_TICK;
                end
                S_TICK: begin
                    if (!cur_v) state_reg <= S_PICK;
                    else begin
                        logic [7:0] ns;
                        ns = (sl_reg[cur_idx] > 0) ? sl_reg[cur_idx] - 8'd1 : 8'd0;
                        sl_reg[cur_idx] <= ns;
                        rt_reg[cur_idx] <= rt_reg[cur_idx] + {32'd0,
                            tick_charge_reg >> fts_pkg::nice_shift(nice_reg[cur_idx])};
                        if (ns > 0 && st_reg[cur_idx] == fts_pkg::ST_RUNNING)
                            state_reg <= S_LOAD;
                        else begin
                            st_reg[cur_idx] <= fts_pkg::ST_READY;
                            tickmode_reg <= 1'b1;
                            state_reg <= S_PICK;
                        end
                    end
                end
                S_PICK: state_reg <= S_PWAIT;
                S_PWAIT: if (scan_done) state_reg <= S_DISP;
                S_DISP: begin
                    if (tickmode_reg && (!scan_found || scan_idx == cur_idx)) begin
                        st_reg[cur_idx] <= fts_pkg::ST_RUNNING;
                        sl_reg[cur_idx] <= slice_ticks_reg;
                    end else if (!scan_found) begin
                        status_reg <= fts_pkg::STS_IDLE;
                        cur_v_reg[cpu_reg] <= 1'b0;
                    end else begin
                        cur_v_reg[cpu_reg] <= 1'b1;
                        cur_reg[cpu_reg] <= scan_idx;
                        st_reg[scan_idx] <= fts_pkg::ST_RUNNING;
                        sl_reg[scan_idx] <= slice_ticks_reg;
                        bound_reg[scan_idx] <= 1'b1;
                        tcpu_reg[scan_idx] <= cpu_reg;
                        fresh_reg <= first_reg[scan_idx];
                        first_reg[scan_idx] <= 1'b0;
                    end
                    state_reg <= S_LOAD;
                end
                S_FREE: state_reg <= S_FWAIT;
                S_FWAIT: if (scan_done) begin
                    if (!scan_found) status_reg <= fts_pkg::STS_FULL;
                    else begin
                        st_reg[scan_idx] <= fts_pkg::ST_READY;
                        bound_reg[scan_idx] <= 1'b0;
                        rt_reg[scan_idx] <= '0;
                        sl_reg[scan_idx] <= slice_ticks_reg;
                        nice_reg[scan_idx] <= nin_reg;
                        wake_reg[scan_idx] <= '0;
                        first_reg[scan_idx] <= 1'b1;
                        newp_reg <= 4'(scan_idx);
                    end
                    state_reg <= S_LOAD;
                end
                S_LOAD: state_reg <= S_LWAIT;
                S_LWAIT: if (scan_done) state_reg <= S_OUT;
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg <= {6'b000000, load_sat, newp_reg, fresh_reg,
                        cur_v ? 4'(cur_idx) : 4'd0, cur_v,
                        cur_v && (!prev_v_reg || cur_idx != prev_reg), status_reg};
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_after_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_OUT) else $error("stray result");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg && $stable(m_data_reg))
        else $error("result dropped");
endmodule

// Shared scan unit: visits one table entry per cycle through a single comparator.
module fts_scan #(
    parameter int ENTRIES = 16,
    parameter int CPUS = 4,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1,
    localparam int LW = $clog2(ENTRIES + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fts_pkg::scan_ctl_t ctl,
    input  logic [CW-1:0]      cpu,
    output logic [IW-1:0]      ptr,
    input  logic [2:0]         e_st,
    input  logic               e_bound,
    input  logic [CW-1:0]      e_cpu,
    input  logic [63:0]        e_rt,
    input  logic [63:0]        best_rt,
    output logic               done,
    output logic               found,
    output logic [IW-1:0]      idx,
    output logic [LW-1:0]      cnt
);
    logic          busy_reg;
    logic [1:0]    mode_reg;
    logic [IW-1:0] ptr_reg;
    logic          found_reg;
    logic [IW-1:0] idx_reg;
    logic [LW-1:0] cnt_reg;
    logic          done_reg;
    logic          eligible;
    logic          take;

    assign ptr = ptr_reg;
    assign done = done_reg;
    assign found = found_reg;
    assign idx = idx_reg;
    assign cnt = cnt_reg;

    // An unbound entry may run anywhere; a bound one only on its own CPU.
    assign eligible = !e_bound || (e_cpu == cpu);

    always_comb begin
        take = 1'b0;
        unique case (mode_reg)
            fts_pkg::SCAN_PICK:
                take = (e_st == fts_pkg::ST_READY || e_st == fts_pkg::ST_RUNNING) &&
                       eligible && (!found_reg || e_rt < best_rt);
            fts_pkg::SCAN_FREE: take = !found_reg && e_st == fts_pkg::ST_FREE;
            default: take = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mode_reg <= fts_pkg::SCAN_PICK;
            ptr_reg <= '0;
            found_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                mode_reg <= ctl.mode;
                ptr_reg <= '0;
                found_reg <= 1'b0;
                cnt_reg <= '0;
            end else if (busy_reg) begin
                if (take) begin
                    found_reg <= 1'b1;
                    idx_reg <= ptr_reg;
                end
                if (mode_reg == fts_pkg::SCAN_LOAD && e_st != fts_pkg::ST_FREE &&
                    e_bound && e_cpu == cpu)
                    cnt_reg <= cnt_reg + 1'b1;
                if (int'(ptr_reg) == ENTRIES - 1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the fair task scheduler with its own scheduling predictor.
module testbench;
    localparam int NTASK = 16;
    localparam int NCPU = 4;
    localparam logic [7:0] NO_TASK = 8'hFF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    // One result item, with the fields that m_tdata carries.
    typedef struct packed {
        logic [1:0] status;
        logic       switched;
        logic       run_valid;
        logic [3:0] run_pid;
        logic       fresh_start;
        logic [3:0] new_pid;
        logic [4:0] load;
    } sched_result_t;

    typedef struct {
        logic [2:0]    op;
        logic [1:0]    cpu;
        logic [3:0]    pid;
        logic [31:0]   sleep_ticks;
        logic [5:0]    nice;
        bit            typed;
        sched_result_t exp;
    } event_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;  // operation, cpu, pid, sleep_ticks, nice (low bit up)
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;  // status, switched, run_valid, run_pid, fresh_start, new_pid, load
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fair_task_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Shadow of the task table, the per-CPU current task and the registers.
    logic [2:0]  tbl_state [NTASK];
    logic [7:0]  tbl_cpu [NTASK];
    logic [63:0] tbl_runtime [NTASK];
    logic [7:0]  tbl_slice [NTASK];
    logic [5:0]  tbl_nice [NTASK];
    logic [31:0] tbl_wake_at [NTASK];
    logic        tbl_first [NTASK];
    logic [31:0] ticks_seen;
    logic [7:0]  running_on [NCPU];
    logic [7:0]  slice_reg;
    logic [31:0] charge_reg;

    sched_result_t pending_results[$];
    int failures = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    function automatic logic [7:0] lowest_runtime_task(input logic [1:0] c);
        logic [7:0] best;
        best = NO_TASK;
        for (int i = 0; i < NTASK; i++) begin
            if ((tbl_state[i] == fts_pkg::ST_READY || tbl_state[i] == fts_pkg::ST_RUNNING) &&
                (tbl_cpu[i] == NO_TASK || tbl_cpu[i] == {6'd0, c})) begin
                if (best == NO_TASK || tbl_runtime[i] < tbl_runtime[best[3:0]])
                    best = 8'(i);
            end
        end
        return best;
    endfunction

    function automatic void dispatch_task(input logic [1:0] c, input logic [7:0] n,
                                          inout logic fresh);
        running_on[c] = n;
        tbl_state[n[3:0]] = fts_pkg::ST_RUNNING;
        tbl_slice[n[3:0]] = slice_reg;
        tbl_cpu[n[3:0]] = {6'd0, c};
        fresh = tbl_first[n[3:0]];
        tbl_first[n[3:0]] = 1'b0;
    endfunction

    // Hands the CPU to the best candidate; returns the idle status when none is left.
    function automatic logic [1:0] pick_next(input logic [1:0] c, inout logic fresh);
        logic [7:0] prev;
        logic [7:0] n;
        prev = running_on[c];
        if (prev != NO_TASK && tbl_state[prev[3:0]] == fts_pkg::ST_RUNNING)
            tbl_state[prev[3:0]] = fts_pkg::ST_READY;
        running_on[c] = NO_TASK;
        n = lowest_runtime_task(c);
        if (n == NO_TASK) return fts_pkg::STS_IDLE;
        dispatch_task(c, n, fresh);
        return fts_pkg::STS_OK;
    endfunction

    function automatic void charge_runtime(input logic [3:0] t);
        logic signed [6:0] n;
        int sh;
        n = 7'($signed(tbl_nice[t]));
        if (n < -7'sd20) n = -7'sd20;
        if (n > 7'sd19) n = 7'sd19;
        sh = (n >= 7'sd10) ? 0 : 10 - int'(n);
        tbl_runtime[t] = tbl_runtime[t] + 64'(charge_reg >> sh);
    endfunction

    // Applies one event to the shadow table and returns the result it must produce.
    function automatic sched_result_t schedule_event(input event_row_t ev);
        sched_result_t r;
        logic [1:0] c;
        logic [7:0] prev;
        logic [7:0] cur;
        logic [7:0] n;
        logic fresh;
        int fi;
        int ld;
        r = '{default: '0};
        fresh = 1'b0;
        c = ev.cpu;
        prev = running_on[c];
        cur = prev;
        case (ev.op)
            fts_pkg::OP_TICK: begin
                ticks_seen = ticks_seen + 32'd1;
                for (int i = 0; i < NTASK; i++)
                    if (tbl_state[i] == fts_pkg::ST_SLEEPING && ticks_seen >= tbl_wake_at[i])
                        tbl_state[i] = fts_pkg::ST_READY;
                if (cur == NO_TASK) begin
                    n = lowest_runtime_task(c);
                    if (n == NO_TASK) r.status = fts_pkg::STS_IDLE;
                    else dispatch_task(c, n, fresh);
                end else begin
                    if (tbl_slice[cur[3:0]] > 0)
                        tbl_slice[cur[3:0]] = tbl_slice[cur[3:0]] - 8'd1;
                    charge_runtime(cur[3:0]);
                    // A task still holding slice and still running keeps the CPU.
                    if (!(tbl_slice[cur[3:0]] > 0 &&
                          tbl_state[cur[3:0]] == fts_pkg::ST_RUNNING)) begin
                        tbl_state[cur[3:0]] = fts_pkg::ST_READY;
                        n = lowest_runtime_task(c);
                        if (n == NO_TASK || n == cur) begin
                            tbl_state[cur[3:0]] = fts_pkg::ST_RUNNING;
                            tbl_slice[cur[3:0]] = slice_reg;
                        end else begin
                            dispatch_task(c, n, fresh);
                        end
                    end
                end
            end
            fts_pkg::OP_YIELD: r.status = pick_next(c, fresh);
            fts_pkg::OP_SLEEP, fts_pkg::OP_BLOCK, fts_pkg::OP_EXIT: begin
                if (cur == NO_TASK) begin
                    r.status = fts_pkg::STS_NOCUR;
                end else begin
                    if (ev.op == fts_pkg::OP_SLEEP) begin
                        tbl_wake_at[cur[3:0]] = ticks_seen + ev.sleep_ticks;
                        tbl_state[cur[3:0]] = fts_pkg::ST_SLEEPING;
                    end else if (ev.op == fts_pkg::OP_BLOCK) begin
                        tbl_state[cur[3:0]] = fts_pkg::ST_BLOCKED;
                    end else begin
                        tbl_state[cur[3:0]] = fts_pkg::ST_FREE;
                        running_on[c] = NO_TASK;
                    end
                    r.status = pick_next(c, fresh);
                end
            end
            fts_pkg::OP_WAKE:
                if (tbl_state[ev.pid] == fts_pkg::ST_BLOCKED)
                    tbl_state[ev.pid] = fts_pkg::ST_READY;
            fts_pkg::OP_READY:
                if (tbl_state[ev.pid] != fts_pkg::ST_FREE)
                    tbl_state[ev.pid] = fts_pkg::ST_READY;
            default: begin
                fi = -1;
                for (int i = NTASK - 1; i >= 0; i--)
                    if (tbl_state[i] == fts_pkg::ST_FREE) fi = i;
                if (fi < 0) begin
                    r.status = fts_pkg::STS_FULL;
                end else begin
                    tbl_state[fi] = fts_pkg::ST_READY;
                    tbl_cpu[fi] = NO_TASK;
                    tbl_runtime[fi] = '0;
                    tbl_slice[fi] = slice_reg;
                    tbl_nice[fi] = ev.nice;
                    tbl_wake_at[fi] = '0;
                    tbl_first[fi] = 1'b1;
                    r.new_pid = 4'(fi);
                end
            end
        endcase
        ld = 0;
        for (int i = 0; i < NTASK; i++)
            if (tbl_state[i] != fts_pkg::ST_FREE && tbl_cpu[i] == {6'd0, c} && ld < 31) ld++;
        cur = running_on[c];
        r.switched = (cur != NO_TASK && cur != prev);
        r.run_valid = (cur != NO_TASK);
        r.run_pid = (cur != NO_TASK) ? cur[3:0] : 4'd0;
        r.fresh_start = fresh;
        r.load = 5'(ld);
        return r;
    endfunction

    // Result checking and the watchdog share the rising edge.
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.switched = m_tdata[2];
            got.run_valid = m_tdata[3];
            got.run_pid = m_tdata[7:4];
            got.fresh_start = m_tdata[8];
            got.new_pid = m_tdata[12:9];
            got.load = m_tdata[17:13];
            if (pending_results.size() == 0) begin
                failures++;
                if (mismatches < 10) $display("unexpected result item %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    failures++;
                    if (mismatches < 10)
                        $display("result mismatch: expected %p, actual %p", want, got);
                    mismatches++;
                end
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // The receiver switches between always ready, random stalls and a fixed pattern.
    initial begin
        int mode;
        int cnt;
        m_tready = 1'b0;
        mode = 0;
        cnt = 0;
        forever begin
            @(negedge aclk);
            cnt++;
            if (cnt % 64 == 0) mode = $urandom_range(2, 0);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(1, 0);
                default: m_tready <= (cnt % 7) >= 3;
            endcase
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Registers change only with the block idle and every result drained.
    task automatic set_config(input logic [7:0] sl, input logic [31:0] ch);
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        apb_write(fts_pkg::REG_SLICE, {24'd0, sl});
        apb_write(fts_pkg::REG_CHARGE, ch);
        slice_reg = sl;
        charge_reg = ch;
    endtask

    int burst_left = 0;

    // Called at a falling edge; returns at a falling edge after the item is taken.
    task automatic send_event(input event_row_t ev);
        sched_result_t predicted;
        s_tdata <= {1'b0, ev.nice, ev.sleep_ticks, ev.pid, ev.cpu, ev.op};
        s_tvalid <= 1'b1;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        predicted = schedule_event(ev);
        pending_results.push_back(ev.typed ? ev.exp : predicted);
        @(negedge aclk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 1);
            if ($urandom_range(3, 0) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge aclk);
            end
        end
    endtask

    function automatic event_row_t random_event();
        event_row_t ev;
        int w;
        ev.typed = 1'b0;
        ev.exp = '{default: '0};
        ev.cpu = 2'($urandom_range(3, 0));
        ev.pid = 4'($urandom_range(15, 0));
        ev.nice = 6'($urandom_range(63, 0));
        ev.sleep_ticks = ($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(6, 0);
        w = $urandom_range(99, 0);
        if (w < 38) ev.op = fts_pkg::OP_TICK;
        else if (w < 46) ev.op = fts_pkg::OP_YIELD;
        else if (w < 56) ev.op = fts_pkg::OP_SLEEP;
        else if (w < 63) ev.op = fts_pkg::OP_BLOCK;
        else if (w < 69) ev.op = fts_pkg::OP_EXIT;
        else if (w < 79) ev.op = fts_pkg::OP_WAKE;
        else if (w < 86) ev.op = fts_pkg::OP_READY;
        else ev.op = fts_pkg::OP_CREATE;
        return ev;
    endfunction

    initial begin
        event_row_t rows[20];
        logic [7:0]  slices[6];
        logic [31:0] charges[6];
        sched_result_t idle_res;
        sched_result_t nocur_res;
        sched_result_t made;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        slice_reg = fts_pkg::SLICE_RESET;
        charge_reg = fts_pkg::CHARGE_RESET;
        ticks_seen = '0;
        for (int i = 0; i < NTASK; i++) begin
            tbl_state[i] = fts_pkg::ST_FREE;
            tbl_cpu[i] = NO_TASK;
            tbl_runtime[i] = '0;
            tbl_slice[i] = fts_pkg::SLICE_RESET;
            tbl_nice[i] = '0;
            tbl_wake_at[i] = '0;
            tbl_first[i] = 1'b0;
        end
        for (int i = 0; i < NCPU; i++) running_on[i] = NO_TASK;

        idle_res = '{default: '0};
        idle_res.status = fts_pkg::STS_IDLE;
        nocur_res = '{default: '0};
        nocur_res.status = fts_pkg::STS_NOCUR;
        made = '{default: '0};

        // Directed events: empty table, nice extremes, every operation and the corner cases.
        rows[0]  = '{fts_pkg::OP_TICK,   2'd0, 4'd0,  32'd0,         6'd0,  1'b1, idle_res};
        rows[1]  = '{fts_pkg::OP_SLEEP,  2'd1, 4'd0,  32'd5,         6'd0,  1'b1, nocur_res};
        rows[2]  = '{fts_pkg::OP_EXIT,   2'd3, 4'd0,  32'd0,         6'd0,  1'b1, nocur_res};
        made.new_pid = 4'd0;
        rows[3]  = '{fts_pkg::OP_CREATE, 2'd0, 4'd0,  32'd0,         6'h2C, 1'b1, made};
        made.new_pid = 4'd1;
        rows[4]  = '{fts_pkg::OP_CREATE, 2'd0, 4'd0,  32'd0,         6'h13, 1'b1, made};
        made.new_pid = 4'd2;
        rows[5]  = '{fts_pkg::OP_CREATE, 2'd0, 4'd0,  32'd0,         6'h1F, 1'b1, made};
        made.new_pid = 4'd3;
        rows[6]  = '{fts_pkg::OP_CREATE, 2'd0, 4'd0,  32'd0,         6'h20, 1'b1, made};
        rows[7]  = '{fts_pkg::OP_TICK,   2'd0, 4'd0,  32'd0,         6'd0,  1'b0, made};
        rows[8]  = '{fts_pkg::OP_TICK,   2'd3, 4'd0,  32'd0,         6'd0,  1'b0, made};
        rows[9]  = '{fts_pkg::OP_TICK,   2'd1, 4'd0,  32'd0,         6'd0,  1'b0, made};
        rows[10] = '{fts_pkg::OP_YIELD,  2'd0, 4'd0,  32'd0,         6'd0,  1'b0, made};
        rows[11] = '{fts_pkg::OP_SLEEP,  2'd0, 4'd0,  32'd2,         6'd0,  1'b0, made};
        rows[12] = '{fts_pkg::OP_BLOCK,  2'd3, 4'd0,  32'd0,         6'd0,  1'b0, made};
        rows[13] = '{fts_pkg::OP_WAKE,   2'd2, 4'd1,  32'd0,         6'd0,  1'b0, made};
        rows[14] = '{fts_pkg::OP_WAKE,   2'd2, 4'd15, 32'd0,         6'd0,  1'b0, made};
        rows[15] = '{fts_pkg::OP_READY,  2'd1, 4'd15, 32'd0,         6'd0,  1'b0, made};
        rows[16] = '{fts_pkg::OP_READY,  2'd2, 4'd2,  32'd0,         6'd0,  1'b0, made};
        rows[17] = '{fts_pkg::OP_SLEEP,  2'd1, 4'd0,  32'hFFFF_FFFF, 6'd0,  1'b0, made};
        rows[18] = '{fts_pkg::OP_TICK,   2'd0, 4'd0,  32'd0,         6'd0,  1'b0, made};
        rows[19] = '{fts_pkg::OP_EXIT,   2'd0, 4'd0,  32'd0,         6'd0,  1'b0, made};

        slices = '{8'd1, 8'd255, 8'd3, 8'd10, 8'd1, 8'd0};
        charges = '{32'd1, 32'hFFFF_FFFF, 32'd1000000, 32'd0, 32'd7, 32'd0};
        slices[5] = 8'($urandom_range(255, 1));
        charges[3] = $urandom;
        charges[5] = ($urandom | 32'd1);

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < 20; i++) send_event(rows[i]);

        // Random phases, each with its own register setting; the sender waits for
        // every result before reprogramming.
        for (int ph = 0; ph < 6; ph++) begin
            s_tvalid <= 1'b0;
            set_config(slices[ph], charges[ph]);
            for (int k = 0; k < 240; k++) send_event(random_event());
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

// ===== fair_task_scheduler.f =====
rtl/core/fts_pkg.sv
rtl/core/fair_task_scheduler.sv
tb/sv/testbench.sv
